@@ src/sha256sh_pkg.sv @@
// Shared types, constants and tables of the SHA-256 stream hasher.
`timescale 1ns / 1ps

package sha256sh_pkg;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  PAD_END_FILL = 6'd56;
  localparam logic [5:0]  FILL_LAST    = 6'd63;
  localparam logic [5:0]  ROUND_LAST   = 6'd63;
  localparam logic [1:0]  PART_FIRST   = 2'd0;
  localparam logic [1:0]  PART_LAST    = 2'd3;
  localparam logic [63:0] BLOCK_BITS   = 64'd512;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_t byte_sel;
    logic      latch_len;
    logic      start;
    logic      round;
    logic      final_add;
    logic      bump_len;
    logic      reinit;
    logic [5:0] round_idx;
    logic [1:0] part;
  } sha_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic pad_end;
  } sha_status_t;

endpackage

@@ src/sha256sh_datapath.sv @@
// Datapath of the SHA-256 stream hasher: message window, round unit, hash words, length.
`timescale 1ns / 1ps

module sha256sh_datapath
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha_cmd_t    cmd,
  input  logic [7:0]  in_byte,
  output sha_status_t status,
  output logic [63:0] digest_part
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [31:0] hash_r [8];
  logic [31:0] v_r [8];
  logic [31:0] win_r [16];
  logic [5:0]  fill_r;
  logic [63:0] bitlen_r;
  logic [63:0] len_r;

  logic [7:0]  byte_nxt;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] mj;
  logic [31:0] w_nxt;

  always_comb begin
    case (cmd.byte_sel)
      BYTE_DATA: byte_nxt = in_byte;
      BYTE_PAD:  byte_nxt = PAD_BYTE;
      BYTE_ZERO: byte_nxt = 8'h00;
      BYTE_LEN:  byte_nxt = len_r[63:56];
      default:   byte_nxt = 8'h00;
    endcase
  end

  // One compression round; win_r[0] is the schedule word of the current round.
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch + ROUND_K[cmd.round_idx] + win_r[0];
    t2    = bsig0(v_r[0]) + mj;
    w_nxt = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= HASH_INIT;
      fill_r   <= '0;
      bitlen_r <= '0;
    end else begin
      if (cmd.shift_byte) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.final_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_r[i] <= hash_r[i] + v_r[i];
        end
        if (cmd.bump_len) begin
          bitlen_r <= bitlen_r + BLOCK_BITS;
        end
      end
      if (cmd.reinit) begin
        hash_r   <= HASH_INIT;
        fill_r   <= '0;
        bitlen_r <= '0;
      end
    end
  end

  // The message bytes enter a 512-bit shift line that doubles as the schedule window.
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[15] <= {win_r[15][23:0], byte_nxt};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_nxt;
    end

    if (cmd.latch_len) begin
      len_r <= bitlen_r + {55'b0, fill_r, 3'b000};
    end else if (cmd.shift_byte && cmd.byte_sel == BYTE_LEN) begin
      len_r <= {len_r[55:0], 8'h00};
    end

    if (cmd.start) begin
      v_r <= hash_r;
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign status.fill_last = (fill_r == FILL_LAST);
  assign status.pad_end   = (fill_r == PAD_END_FILL);
  assign digest_part      = {hash_r[{cmd.part, 1'b0}], hash_r[{cmd.part, 1'b1}]};

endmodule

@@ src/sha256sh_ctrl.sv @@
// Controller of the SHA-256 stream hasher: request handshakes, padding and round sequencing.
`timescale 1ns / 1ps

module sha256sh_ctrl
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_op,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,
  output logic [1:0]  out_part,
  input  sha_status_t status,
  output sha_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_COMPRESS,
    S_FINAL,
    S_OUT
  } state_t;

  // What follows the compression that is running.
  typedef enum logic [1:0] {
    M_NORMAL,
    M_PAD,
    M_LAST
  } mode_t;

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [5:0] round_r, round_nxt;
  logic [1:0] part_r, part_nxt;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    round_nxt = round_r;
    part_nxt  = part_r;

    cmd.shift_byte = 1'b0;
    cmd.byte_sel   = BYTE_ZERO;
    cmd.latch_len  = 1'b0;
    cmd.start      = 1'b0;
    cmd.round      = 1'b0;
    cmd.final_add  = 1'b0;
    cmd.bump_len   = 1'b0;
    cmd.reinit     = 1'b0;
    cmd.round_idx  = round_r;
    cmd.part       = part_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.shift_byte = 1'b1;
          if (!in_op) begin
            cmd.byte_sel = BYTE_DATA;
            if (status.fill_last) begin
              cmd.start = 1'b1;
              mode_nxt  = M_NORMAL;
              round_nxt = '0;
              state_nxt = S_COMPRESS;
            end
          end else begin
            cmd.byte_sel  = BYTE_PAD;
            cmd.latch_len = 1'b1;
            if (status.fill_last) begin
              cmd.start = 1'b1;
              mode_nxt  = M_PAD;
              round_nxt = '0;
              state_nxt = S_COMPRESS;
            end else begin
              state_nxt = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        if (status.pad_end) begin
          state_nxt = S_LEN;
        end else begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = BYTE_ZERO;
          if (status.fill_last) begin
            cmd.start = 1'b1;
            mode_nxt  = M_PAD;
            round_nxt = '0;
            state_nxt = S_COMPRESS;
          end
        end
      end
      S_LEN: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = BYTE_LEN;
        if (status.fill_last) begin
          cmd.start = 1'b1;
          mode_nxt  = M_LAST;
          round_nxt = '0;
          state_nxt = S_COMPRESS;
        end
      end
      S_COMPRESS: begin
        cmd.round = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        cmd.bump_len  = (mode_r == M_NORMAL);
        case (mode_r)
          M_NORMAL: state_nxt = S_IDLE;
          M_PAD:    state_nxt = S_PAD;
          M_LAST: begin
            part_nxt  = PART_FIRST;
            state_nxt = S_OUT;
          end
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_tready) begin
          part_nxt = part_r + 2'd1;
          if (part_r == PART_LAST) begin
            cmd.reinit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_NORMAL;
      round_r <= '0;
      part_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      round_r <= round_nxt;
      part_r  <= part_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = (part_r == PART_LAST);
  assign out_part   = part_r;

endmodule

@@ src/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level.
//
// Input channel: each request carries one message byte (in_tuser low) or a finish
// command (in_tuser high, in_tdata ignored). Output channel: a finished message gives
// four requests, the 256-bit digest in 64-bit big-endian parts, part 0 first, the part
// number on out_tuser and out_tlast on part 3.
// The 64th byte of a block starts the compression, one round per cycle on a single round
// unit; no byte is taken until the compression and its final addition are done.
// A finish shifts in the padding and the length a byte at a time and runs one or two
// compressions; out_tvalid rises after the last of them and its final addition.
// While the digest is out, no input is taken; a stalled receiver holds the current part
// steady. After part 3 is taken the hash words and length return to their initial
// values. Synchronous reset gives the initial hash words and an empty message.
`timescale 1ns / 1ps

module sha256_stream_hasher
  import sha256sh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_part
  output logic [1:0]  out_tuser,  // [1:0] part_index
  output logic        out_tlast
);

  sha_cmd_t    cmd;
  sha_status_t status;

  sha256sh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_part   (out_tuser),
    .status     (status),
    .cmd        (cmd)
  );

  sha256sh_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .status      (status),
    .digest_part (out_tdata)
  );

endmodule

@@ src/sha256sh_checker.sv @@
// Port-level checks of the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps

module sha256sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled digest part stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("digest part changed while stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 2'd3)))
    else $error("tlast does not mark the final part");

  // Parts follow one another without a gap until the last one is taken.
  a_part_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser == $past(out_tuser) + 2'd1))
    else $error("digest parts out of order");

  a_no_input_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while the digest is out");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("digest shown after reset");

endmodule

bind sha256_stream_hasher sha256sh_checker u_checker (.*);

@@ sim/sha256_stream_hasher_tb.sv @@
// Self-checking testbench of the SHA-256 stream hasher, with its own digest predictor.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RAND_ITEMS = 160;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths around the padding and block boundaries.
  localparam int EDGE_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  typedef struct packed {
    logic         op;
    logic [7:0]   data;
    logic         typed;   // digest below is known by heart
    logic [255:0] digest;
  } stim_row_t;

  localparam int DIR_ROWS = 17;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
    '{OP_APPEND, 8'h61, 1'b0, 256'd0},
    '{OP_APPEND, 8'h62, 1'b0, 256'd0},
    '{OP_APPEND, 8'h63, 1'b0, 256'd0},
    '{OP_FINISH, 8'h00, 1'b1, ABC_DIGEST},
    '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
    '{OP_APPEND, 8'h00, 1'b0, 256'd0},
    '{OP_APPEND, 8'hff, 1'b0, 256'd0},
    '{OP_APPEND, 8'h55, 1'b0, 256'd0},
    '{OP_APPEND, 8'haa, 1'b0, 256'd0},
    '{OP_FINISH, 8'h5a, 1'b0, 256'd0},
    '{OP_APPEND, 8'h80, 1'b0, 256'd0},
    '{OP_FINISH, 8'ha5, 1'b0, 256'd0},
    '{OP_APPEND, 8'h61, 1'b0, 256'd0},
    '{OP_APPEND, 8'h62, 1'b0, 256'd0},
    '{OP_APPEND, 8'h63, 1'b0, 256'd0},
    '{OP_FINISH, 8'hff, 1'b1, ABC_DIGEST}
  };

  typedef struct {
    logic [63:0] part;
    logic [1:0]  idx;
    logic        last;
  } digest_part_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Predictor state.
  logic [31:0] h_st [8];
  logic [7:0]  msg_blk [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  digest_part_t digest_parts_due [$];
  int errors = 0;
  int items_sent = 0;
  int rx_stall = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  sha256_stream_hasher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_reinit();
    for (int i = 0; i < 8; i++) h_st[i] = IV[i];
    blk_fill = 6'd0;
    msg_bits = 64'd0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_blk[4*r], msg_blk[4*r+1], msg_blk[4*r+2], msg_blk[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {h_st[0], h_st[1], h_st[2], h_st[3],
                                h_st[4], h_st[5], h_st[6], h_st[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) + RC[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h_st[0] += a; h_st[1] += b; h_st[2] += c; h_st[3] += d;
    h_st[4] += e; h_st[5] += f; h_st[6] += g; h_st[7] += h;
  endfunction

  // Advances the predicted hash state by one request; a finish queues the four
  // digest parts unless the caller supplies them itself.
  function automatic void absorb_item(logic op, logic [7:0] data, bit queue_parts);
    logic [63:0] total;
    digest_part_t p;
    int n;
    if (op == OP_APPEND) begin
      msg_blk[blk_fill] = data;
      blk_fill = blk_fill + 6'd1;
      if (blk_fill == 6'd0) begin
        compress_blk();
        msg_bits += 64'd512;
      end
    end else begin
      n = int'(blk_fill);
      total = msg_bits + 64'(n) * 64'd8;
      msg_blk[n] = 8'h80;
      n++;
      // No room left for the length: pad out this block and start another.
      if (n > 56) begin
        while (n < 64) begin
          msg_blk[n] = 8'h00;
          n++;
        end
        compress_blk();
        n = 0;
      end
      while (n < 56) begin
        msg_blk[n] = 8'h00;
        n++;
      end
      for (int i = 0; i < 8; i++) msg_blk[56+i] = total[63-8*i -: 8];
      compress_blk();
      if (queue_parts) begin
        for (int k = 0; k < 4; k++) begin
          p.part = {h_st[2*k], h_st[2*k+1]};
          p.idx = 2'(k);
          p.last = (k == 3);
          digest_parts_due = {digest_parts_due, p};
        end
      end
      hash_reinit();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_item(logic op, logic [7:0] data, bit typed, logic [255:0] digest);
    int gap;
    digest_part_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    absorb_item(op, data, !typed);
    if (typed && op == OP_FINISH) begin
      for (int k = 0; k < 4; k++) begin
        p.part = digest[255-64*k -: 64];
        p.idx = 2'(k);
        p.last = (k == 3);
        digest_parts_due = {digest_parts_due, p};
      end
    end
  endtask

  task automatic wait_digests_out();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_parts_due.size() != 0);
  endtask

  task automatic check_part();
    digest_part_t p;
    if (digest_parts_due.size() == 0) begin
      note_error($sformatf("unexpected digest part %h idx %0d", out_tdata, out_tuser));
    end else begin
      p = digest_parts_due.pop_front();
      if (out_tdata !== p.part)
        note_error($sformatf("part %0d data got %h want %h", p.idx, out_tdata, p.part));
      if (out_tuser !== p.idx)
        note_error($sformatf("part index got %0d want %0d", out_tuser, p.idx));
      if (out_tlast !== p.last)
        note_error($sformatf("part %0d last got %b want %b", p.idx, out_tlast, p.last));
    end
  endtask

  // Receiver side with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_part();
      if (rx_stall == 0 && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("sha256_stream_hasher_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int msgs, len;
    hash_reinit();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].digest);
    wait_digests_out();

    msgs = 0;
    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 4) len = EDGE_LEN[$urandom_range(0, 8)];
      else len = $urandom_range(0, 12);
      // Keep the run close to its item budget.
      if (len > RAND_ITEMS - items_sent) len = $urandom_range(0, 12);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len; j++)
        send_item(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 256'd0);
      send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'd0);
      msgs++;
      if (msgs % 5 == 0) wait_digests_out();
    end
    no_gaps = 1'b0;

    wait_digests_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_parts_due.size() != 0)
      note_error($sformatf("%0d digest parts never arrived", digest_parts_due.size()));
    if (errors == 0) begin
      $display("sha256_stream_hasher_tb passed");
    end else begin
      $display("sha256_stream_hasher_tb failed");
    end
    $finish;
  end

endmodule
